[design/fss_pkg.sv]
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Shared widths, scoring constants, controller states and byte helpers.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int MaxLen = 256;
  localparam int AddrW  = $clog2(MaxLen);
  localparam int LenW   = AddrW + 1;
  localparam int ScoreW = 18;
  localparam int RunW   = 2 * LenW + 4;

  localparam int AdjBase   = 12;
  localparam int AdjStep   = 3;
  localparam int WordBonus = 18;
  localparam int ScoreMin  = -1024;
  localparam int ScoreMax  = 131071;

  localparam logic [1:0] TierExact = 2'd0;
  localparam logic [1:0] TierPrefix = 2'd1;
  localparam logic [1:0] TierWord = 2'd2;
  localparam logic [1:0] TierOther = 2'd3;

  localparam logic OpCand  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StPref,
    StScan,
    StFin
  } state_e;

  function automatic logic [7:0] to_lower(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5a]}) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
  endfunction

endpackage

[design/fss_cand_ram.sv]
// ----------------------------------------------------------------------------
// Candidate byte store
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fss_cand_ram (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [fss_pkg::AddrW-1:0] wr_addr_i,
  input  logic [7:0]                wr_data_i,
  input  logic                      rd_en_i,
  input  logic [fss_pkg::AddrW-1:0] rd_addr_i,
  output logic [7:0]                rd_data_o
);

  logic [7:0] mem [fss_pkg::MaxLen];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

[design/fuzzy_subsequence_scorer_unit.sv]
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer
// Scores a query against a stored candidate string by greedy forward search.
// ----------------------------------------------------------------------------
// Usage: candidate beats (op 0) that carry a byte load it lowercased into
// the candidate store, and the last flag closes the string. Query beats (op 1)
// follow. A query beat with last set yields exactly one result beat.
// A query beat with a byte first checks the prefix, then, unless the search
// has already failed, runs the forward scan, which steps through the store
// one read per cycle; the read port of that single memory sets the rate. A
// final query beat then passes through a finish state that forms the result.
// in_stall_o is high while a query byte or a result is being worked on.
// The result sits in an output register; while the receiver stalls, new
// beats are still taken, and only the next result waits for the register.
// Reset clears all lengths, flags and the score; the store is not cleared,
// since only bytes written for the current candidate are ever read.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       in_op_i,
  input  logic                       in_has_byte_i,
  input  logic [7:0]                 in_data_byte_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       out_matched_o,
  output logic [1:0]                 out_tier_o,
  output logic [fss_pkg::ScoreW-1:0] out_score_o,
  output logic                       out_overflow_o
);

  localparam int AddrW = fss_pkg::AddrW;
  localparam int LenW  = fss_pkg::LenW;
  localparam int RunW  = fss_pkg::RunW;
  localparam logic [LenW-1:0] MaxLenL = LenW'(fss_pkg::MaxLen);

  fss_pkg::state_e state_q, state_d;

  logic [LenW-1:0] cand_len_q, cand_len_d;
  logic            cand_fresh_q, cand_fresh_d;
  logic            too_long_q, too_long_d;
  logic [LenW-1:0] query_len_q, query_len_d;
  logic [LenW-1:0] search_pos_q, search_pos_d;
  logic [RunW-1:0] run_score_q, run_score_d;
  logic [LenW-1:0] adj_run_q, adj_run_d;
  logic            has_hit_q, has_hit_d;
  logic            first_word_q, first_word_d;
  logic            search_failed_q, search_failed_d;
  logic            prefix_ok_q, prefix_ok_d;
  logic            q_over_q, q_over_d;
  logic [7:0]      qbyte_q, qbyte_d;
  logic            last_q, last_d;
  logic [7:0]      hit_byte_q, hit_byte_d;
  logic [7:0]      scan_prev_q, scan_prev_d;
  logic [LenW-1:0] ptr_q, ptr_d;
  logic            pchk_q, pchk_d;

  logic              out_valid_q, out_valid_d;
  logic              out_matched_q, out_matched_d;
  logic [1:0]        out_tier_q, out_tier_d;
  logic [fss_pkg::ScoreW-1:0] out_score_q, out_score_d;
  logic              out_overflow_q, out_overflow_d;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  logic            accept;
  logic            qs_clr;
  logic [LenW-1:0] clen_eff;
  logic [LenW-1:0] nxt_ptr;
  logic            word;
  logic [RunW-1:0] delta;
  logic [RunW-1:0] fin_s;
  logic            fin_ovf;
  logic            fin_match;
  logic            out_free;

  fss_cand_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != fss_pkg::StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d         = state_q;
    cand_len_d      = cand_len_q;
    cand_fresh_d    = cand_fresh_q;
    too_long_d      = too_long_q;
    query_len_d     = query_len_q;
    search_pos_d    = search_pos_q;
    run_score_d     = run_score_q;
    adj_run_d       = adj_run_q;
    has_hit_d       = has_hit_q;
    first_word_d    = first_word_q;
    search_failed_d = search_failed_q;
    prefix_ok_d     = prefix_ok_q;
    q_over_d        = q_over_q;
    qbyte_d         = qbyte_q;
    last_d          = last_q;
    hit_byte_d      = hit_byte_q;
    scan_prev_d     = scan_prev_q;
    ptr_d           = ptr_q;
    pchk_d          = pchk_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_matched_d   = out_matched_q;
    out_tier_d      = out_tier_q;
    out_score_d     = out_score_q;
    out_overflow_d  = out_overflow_q;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = fss_pkg::to_lower(in_data_byte_i);
    rd_en           = 1'b0;
    rd_addr         = '0;
    qs_clr          = 1'b0;
    clen_eff        = cand_fresh_q ? '0 : cand_len_q;
    nxt_ptr         = ptr_q + LenW'(1);
    word            = (ptr_q == '0) || !fss_pkg::is_alnum(scan_prev_q);
    delta           = '0;
    fin_ovf         = too_long_q || q_over_q;
    fin_match       = !fin_ovf && !search_failed_q;
    fin_s           = run_score_q - RunW'(cand_len_q) + RunW'(query_len_q);

    case (state_q)
      fss_pkg::StIdle: begin
        if (accept && (in_op_i == fss_pkg::OpCand)) begin
          cand_len_d = clen_eff;
          if (cand_fresh_q) begin
            too_long_d = 1'b0;
          end
          if (in_has_byte_i) begin
            if (clen_eff < MaxLenL) begin
              wr_en      = 1'b1;
              wr_addr    = clen_eff[AddrW-1:0];
              cand_len_d = clen_eff + LenW'(1);
            end else begin
              too_long_d = 1'b1;
            end
          end
          cand_fresh_d = in_last_i;
          qs_clr       = 1'b1;
        end else if (accept) begin
          last_d = in_last_i;
          if (in_has_byte_i && (query_len_q >= MaxLenL)) begin
            q_over_d        = 1'b1;
            search_failed_d = 1'b1;
            if (in_last_i) begin
              state_d = fss_pkg::StFin;
            end
          end else if (in_has_byte_i) begin
            query_len_d = query_len_q + LenW'(1);
            qbyte_d     = fss_pkg::to_lower(in_data_byte_i);
            pchk_d      = (query_len_q < cand_len_q);
            rd_en       = pchk_d;
            rd_addr     = query_len_q[AddrW-1:0];
            state_d     = fss_pkg::StPref;
          end else if (in_last_i) begin
            state_d = fss_pkg::StFin;
          end
        end
      end
      fss_pkg::StPref: begin
        if (!pchk_q || (rd_data != qbyte_q)) begin
          prefix_ok_d = 1'b0;
        end
        if (search_failed_q) begin
          state_d = last_q ? fss_pkg::StFin : fss_pkg::StIdle;
        end else if (search_pos_q >= cand_len_q) begin
          search_failed_d = 1'b1;
          state_d = last_q ? fss_pkg::StFin : fss_pkg::StIdle;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = search_pos_q[AddrW-1:0];
          ptr_d       = search_pos_q;
          scan_prev_d = hit_byte_q;
          state_d     = fss_pkg::StScan;
        end
      end
      fss_pkg::StScan: begin
        if (rd_data == qbyte_q) begin
          if (ptr_q == search_pos_q) begin
            adj_run_d = adj_run_q + LenW'(1);
            delta = RunW'(fss_pkg::AdjBase) + RunW'(fss_pkg::AdjStep) * RunW'(adj_run_d);
          end else begin
            adj_run_d = '0;
            delta = '0 - RunW'(ptr_q - search_pos_q);
          end
          if (word) begin
            delta = delta + RunW'(fss_pkg::WordBonus);
          end
          run_score_d = run_score_q + delta;
          if (!has_hit_q) begin
            has_hit_d    = 1'b1;
            first_word_d = word;
          end
          search_pos_d = nxt_ptr;
          hit_byte_d   = qbyte_q;
          state_d      = last_q ? fss_pkg::StFin : fss_pkg::StIdle;
        end else begin
          scan_prev_d = rd_data;
          if (nxt_ptr >= cand_len_q) begin
            search_failed_d = 1'b1;
            state_d = last_q ? fss_pkg::StFin : fss_pkg::StIdle;
          end else begin
            rd_en   = 1'b1;
            rd_addr = nxt_ptr[AddrW-1:0];
            ptr_d   = nxt_ptr;
          end
        end
      end
      fss_pkg::StFin: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_matched_d  = fin_match;
          out_overflow_d = fin_ovf;
          out_tier_d     = fss_pkg::TierExact;
          out_score_d    = '0;
          if (fin_match && (query_len_q != '0)) begin
            if (prefix_ok_q && (query_len_q == cand_len_q)) begin
              out_tier_d = fss_pkg::TierExact;
            end else if (prefix_ok_q) begin
              out_tier_d = fss_pkg::TierPrefix;
            end else if (first_word_q) begin
              out_tier_d = fss_pkg::TierWord;
            end else begin
              out_tier_d = fss_pkg::TierOther;
            end
            if ($signed(fin_s) < $signed(RunW'(fss_pkg::ScoreMin))) begin
              out_score_d = fss_pkg::ScoreW'(fss_pkg::ScoreMin);
            end else if ($signed(fin_s) > $signed(RunW'(fss_pkg::ScoreMax))) begin
              out_score_d = fss_pkg::ScoreW'(fss_pkg::ScoreMax);
            end else begin
              out_score_d = fin_s[fss_pkg::ScoreW-1:0];
            end
          end
          qs_clr  = 1'b1;
          state_d = fss_pkg::StIdle;
        end
      end
      default: begin
        state_d = fss_pkg::StIdle;
      end
    endcase

    if (qs_clr) begin
      query_len_d     = '0;
      search_pos_d    = '0;
      run_score_d     = '0;
      adj_run_d       = '0;
      has_hit_d       = 1'b0;
      first_word_d    = 1'b0;
      search_failed_d = 1'b0;
      prefix_ok_d     = 1'b1;
      q_over_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= fss_pkg::StIdle;
      cand_len_q      <= '0;
      cand_fresh_q    <= 1'b1;
      too_long_q      <= 1'b0;
      query_len_q     <= '0;
      search_pos_q    <= '0;
      run_score_q     <= '0;
      adj_run_q       <= '0;
      has_hit_q       <= 1'b0;
      first_word_q    <= 1'b0;
      search_failed_q <= 1'b0;
      prefix_ok_q     <= 1'b1;
      q_over_q        <= 1'b0;
      last_q          <= 1'b0;
      hit_byte_q      <= '0;
      pchk_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      cand_len_q      <= cand_len_d;
      cand_fresh_q    <= cand_fresh_d;
      too_long_q      <= too_long_d;
      query_len_q     <= query_len_d;
      search_pos_q    <= search_pos_d;
      run_score_q     <= run_score_d;
      adj_run_q       <= adj_run_d;
      has_hit_q       <= has_hit_d;
      first_word_q    <= first_word_d;
      search_failed_q <= search_failed_d;
      prefix_ok_q     <= prefix_ok_d;
      q_over_q        <= q_over_d;
      last_q          <= last_d;
      hit_byte_q      <= hit_byte_d;
      pchk_q          <= pchk_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qbyte_q        <= qbyte_d;
    scan_prev_q    <= scan_prev_d;
    ptr_q          <= ptr_d;
    out_matched_q  <= out_matched_d;
    out_tier_q     <= out_tier_d;
    out_score_q    <= out_score_d;
    out_overflow_q <= out_overflow_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_matched_o  = out_matched_q;
  assign out_tier_o     = out_tier_q;
  assign out_score_o    = out_score_q;
  assign out_overflow_o = out_overflow_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer testbench
// Feeds candidate and query beats through the valid/stall handshake. A
// directed table comes first, then random strings that are mostly real
// subsequences, prefixes and exact copies of the candidate, with noise and
// abandoned strings mixed in. A behavioral scorer predicts each result not
// fixed by the directed table, and the results are checked in order, field
// by field. Both sides idle at random, the receiver holds off once for a
// long stretch, and the sender drains the block now and then.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumItems    = 1750;
  localparam int IdleWeight  = 37;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 20000;
  localparam int DrainCycles = 600;
  localparam int HitBase     = 12;
  localparam int RunStep     = 3;
  localparam int StartBonus  = 18;
  localparam longint ScoreFloor = -1024;
  localparam longint ScoreCeil  = 131071;
  localparam logic [9:0] NoHit  = 10'h3ff;

  typedef struct packed {
    logic                       matched;
    logic [1:0]                 tier;
    logic [fss_pkg::ScoreW-1:0] score;
    logic                       overflow;
  } result_t;

  typedef struct packed {
    logic       op;
    logic       has_byte;
    logic [7:0] data;
    logic       last;
    logic       fixed;
    result_t    want;
    logic       drain;
  } beat_t;

  typedef struct packed {
    logic       op;
    logic       has_byte;
    logic [7:0] data;
    logic       last;
    logic [9:0] reps;
    logic       fixed;
    result_t    want;
  } row_t;

  localparam result_t NoWant   = '0;
  localparam result_t EmptyHit =
    '{1'b1, fss_pkg::TierExact, fss_pkg::ScoreW'(0), 1'b0};
  localparam result_t NoMatch  =
    '{1'b0, fss_pkg::TierExact, fss_pkg::ScoreW'(0), 1'b0};
  localparam result_t TooLong  =
    '{1'b0, fss_pkg::TierExact, fss_pkg::ScoreW'(0), 1'b1};
  localparam result_t TwoExact =
    '{1'b1, fss_pkg::TierExact, fss_pkg::ScoreW'(51), 1'b0};

  localparam logic OpC = fss_pkg::OpCand;
  localparam logic OpQ = fss_pkg::OpQuery;

  localparam int NumRows = 27;

  row_t dir_tab [NumRows] = '{
    '{OpQ, 1'b0, 8'h00, 1'b1, 10'd1,   1'b1, EmptyHit},
    '{OpC, 1'b1, "A",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b1, "b",   1'b1, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, "a",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, "B",   1'b1, 10'd1,   1'b1, TwoExact},
    '{OpQ, 1'b1, "z",   1'b1, 10'd1,   1'b1, NoMatch},
    '{OpQ, 1'b0, 8'hff, 1'b1, 10'd1,   1'b1, EmptyHit},
    '{OpC, 1'b1, "a",   1'b1, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, "b",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b1, "X",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, "x",   1'b1, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b1, "_",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b1, "Y",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b1, 8'h00, 1'b0, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b0, "Z",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpC, 1'b1, 8'hff, 1'b1, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, "y",   1'b0, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b0, 8'ha5, 1'b0, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, 8'hff, 1'b1, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, 8'h00, 1'b1, 10'd1,   1'b0, NoWant},
    '{OpQ, 1'b1, "@",   1'b1, 10'd1,   1'b1, NoMatch},
    '{OpC, 1'b1, "a",   1'b1, 10'd257, 1'b0, NoWant},
    '{OpQ, 1'b1, "A",   1'b1, 10'd1,   1'b1, TooLong},
    '{OpC, 1'b1, "Z",   1'b1, 10'd256, 1'b0, NoWant},
    '{OpQ, 1'b1, "z",   1'b1, 10'd256, 1'b0, NoWant},
    '{OpQ, 1'b1, "z",   1'b1, 10'd257, 1'b1, TooLong},
    '{OpQ, 1'b1, "[",   1'b1, 10'd1,   1'b1, NoMatch}
  };

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic                       in_op_i        = 1'b0;
  logic                       in_has_byte_i  = 1'b0;
  logic [7:0]                 in_data_byte_i = 8'h00;
  logic                       in_last_i      = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic                       out_matched_o;
  logic [1:0]                 out_tier_o;
  logic [fss_pkg::ScoreW-1:0] out_score_o;
  logic                       out_overflow_o;

  fuzzy_subsequence_scorer_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  beat_t   stim_q [$];
  result_t score_q [$];
  beat_t   cur_beat = '0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;
  bit      hold_now = 1'b0;
  bit      drain_next = 1'b0;

  logic [7:0]               cand_mem [fss_pkg::MaxLen];
  logic [fss_pkg::LenW-1:0] cand_n;
  logic [fss_pkg::LenW-1:0] qry_n;
  logic [fss_pkg::LenW-1:0] scan_pos;
  logic [fss_pkg::LenW-1:0] adj_run;
  logic [9:0]               first_at;
  longint                   run_pts;
  bit                       scan_failed;
  bit                       prefix_match;
  bit                       cand_over;
  bit                       qry_over;
  bit                       cand_new;
  bit                       qry_new;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void new_query();
    qry_n        = '0;
    scan_pos     = '0;
    run_pts      = 0;
    adj_run      = '0;
    first_at     = NoHit;
    scan_failed  = 1'b0;
    prefix_match = 1'b1;
    qry_over     = 1'b0;
  endfunction

  function automatic void take_query_byte(logic [7:0] q);
    int k;
    int hit_at;
    hit_at = -1;
    if (qry_n >= fss_pkg::MaxLen) begin
      qry_over    = 1'b1;
      scan_failed = 1'b1;
      return;
    end
    if (!(qry_n < cand_n && cand_mem[qry_n[fss_pkg::AddrW-1:0]] == q)) begin
      prefix_match = 1'b0;
    end
    qry_n++;
    if (scan_failed) begin
      return;
    end
    for (k = int'(scan_pos); k < int'(cand_n) && hit_at < 0; k++) begin
      if (cand_mem[k] == q) begin
        hit_at = k;
      end
    end
    if (hit_at < 0) begin
      scan_failed = 1'b1;
      return;
    end
    if (first_at == NoHit) begin
      first_at = hit_at[9:0];
    end
    if (hit_at == int'(scan_pos)) begin
      adj_run++;
      run_pts += HitBase + RunStep * longint'(adj_run);
    end else begin
      adj_run = '0;
      run_pts -= longint'(hit_at) - longint'(scan_pos);
    end
    if (hit_at == 0 || !word_char(cand_mem[hit_at - 1])) begin
      run_pts += StartBonus;
    end
    scan_pos = fss_pkg::LenW'(hit_at + 1);
  endfunction

  function automatic void clear_scorer();
    cand_n    = '0;
    cand_over = 1'b0;
    cand_new  = 1'b1;
    qry_new   = 1'b1;
    new_query();
  endfunction

  // Returns 1 when the beat closes a query and a result is due.
  function automatic bit score_beat(beat_t b, output result_t r);
    logic [7:0] c;
    longint     pts;
    bit         ovf;
    bit         ok;
    bit         exact;
    bit         word;
    c = fold_case(b.data);
    r = '0;
    if (b.op == fss_pkg::OpCand) begin
      if (cand_new) begin
        cand_n    = '0;
        cand_over = 1'b0;
      end
      if (b.has_byte) begin
        if (cand_n < fss_pkg::MaxLen) begin
          cand_mem[cand_n[fss_pkg::AddrW-1:0]] = c;
          cand_n++;
        end else begin
          cand_over = 1'b1;
        end
      end
      cand_new = b.last;
      qry_new  = 1'b1;
      return 1'b0;
    end
    if (qry_new) begin
      new_query();
    end
    qry_new = b.last;
    if (b.has_byte) begin
      take_query_byte(c);
    end
    if (!b.last) begin
      return 1'b0;
    end
    ovf        = cand_over || qry_over;
    ok         = !ovf && !scan_failed;
    r.matched  = ok;
    r.overflow = ovf;
    if (ok && qry_n > 0) begin
      exact = prefix_match && qry_n == cand_n;
      word  = first_at == 0 ||
              (first_at < cand_n &&
               !word_char(cand_mem[first_at[fss_pkg::AddrW-1:0] - 1'b1]));
      pts = run_pts - (longint'(cand_n) - longint'(qry_n));
      if (pts < ScoreFloor) begin
        pts = ScoreFloor;
      end
      if (pts > ScoreCeil) begin
        pts = ScoreCeil;
      end
      r.score = pts[fss_pkg::ScoreW-1:0];
      r.tier  = exact ? fss_pkg::TierExact :
                prefix_match ? fss_pkg::TierPrefix :
                word ? fss_pkg::TierWord : fss_pkg::TierOther;
    end
    return 1'b1;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t calc;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got   = '{out_matched_o, out_tier_o, out_score_o, out_overflow_o};
        if (score_q.size() == 0) begin
          mismatches++;
          $error("result with nothing pending: matched %0d tier %0d score %0d overflow %0d",
                 got.matched, got.tier, $signed(got.score), got.overflow);
        end else begin
          calc = score_q.pop_front();
          check_field("matched", calc.matched, got.matched);
          check_field("tier", calc.tier, got.tier);
          check_field("score", longint'($signed(calc.score)), longint'($signed(got.score)));
          check_field("overflow", calc.overflow, got.overflow);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        if (score_beat(cur_beat, calc)) begin
          score_q.insert(score_q.size(), cur_beat.fixed ? cur_beat.want : calc);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : sink
    forever begin
      @(negedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall_i <= !steady && ($urandom_range(99) < IdleWeight);
    end
  end

  task automatic add_beat(logic op, logic has, logic [7:0] d, logic last);
    beat_t b;
    b          = '0;
    b.op       = op;
    b.has_byte = has;
    b.data     = d;
    b.last     = last;
    b.drain    = drain_next;
    drain_next = 1'b0;
    stim_q.insert(stim_q.size(), b);
  endtask

  function automatic logic [7:0] pick_char();
    string pool;
    pool = "abcABC_ -.09xZ";
    if ($urandom_range(7) == 0) begin
      return 8'($urandom_range(255));
    end
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic build_directed();
    beat_t b;
    int    j;
    int    k;
    for (j = 0; j < NumRows; j++) begin
      for (k = 0; k < int'(dir_tab[j].reps); k++) begin
        b          = '0;
        b.op       = dir_tab[j].op;
        b.has_byte = dir_tab[j].has_byte;
        b.data     = dir_tab[j].data;
        b.last     = dir_tab[j].last && k == int'(dir_tab[j].reps) - 1;
        b.fixed    = dir_tab[j].fixed && k == int'(dir_tab[j].reps) - 1;
        b.want     = dir_tab[j].want;
        stim_q.insert(stim_q.size(), b);
      end
    end
  endtask

  task automatic build_random();
    logic [7:0] cand_txt [$];
    logic [7:0] qry_txt [$];
    logic [7:0] ch;
    int         n;
    int         k;
    int         r;
    int         mode;
    int         len;
    bit         open;
    bit         tail;
    drain_next = 1'b1;
    while (stim_q.size() < NumItems) begin
      r = $urandom_range(99);
      if (r < 3) begin
        n = $urandom_range(250, 262);
      end else if (r < 25) begin
        n = $urandom_range(11, 40);
      end else begin
        n = $urandom_range(0, 10);
      end
      if ($urandom_range(24) == 0) begin
        drain_next = 1'b1;
      end
      open = $urandom_range(19) == 0;
      cand_txt.delete();
      for (k = 0; k < n; k++) begin
        ch = pick_char();
        cand_txt.insert(cand_txt.size(), fold_case(ch));
        if ($urandom_range(15) == 0) begin
          add_beat(fss_pkg::OpCand, 1'b0, 8'($urandom), 1'b0);
        end
        add_beat(fss_pkg::OpCand, 1'b1, ch, k == n - 1 && !open);
      end
      if (n == 0 && !open) begin
        add_beat(fss_pkg::OpCand, 1'b0, 8'($urandom), 1'b1);
      end
      repeat ($urandom_range(1, 4)) begin
        mode = $urandom_range(99);
        open = mode >= 95;
        tail = $urandom_range(9) == 0;
        qry_txt.delete();
        if (mode < 40 || open) begin
          foreach (cand_txt[k]) begin
            if ($urandom_range(1)) begin
              qry_txt.insert(qry_txt.size(), cand_txt[k]);
            end
          end
        end else if (mode < 60) begin
          len = $urandom_range(cand_txt.size());
          for (k = 0; k < len; k++) begin
            qry_txt.insert(qry_txt.size(), cand_txt[k]);
          end
        end else if (mode < 72) begin
          qry_txt = cand_txt;
        end else if (mode < 86) begin
          repeat ($urandom_range(1, 5)) qry_txt.insert(qry_txt.size(), pick_char());
        end else if (mode < 88) begin
          repeat ($urandom_range(255, 260)) qry_txt.insert(qry_txt.size(), pick_char());
        end
        if (qry_txt.size() == 0) begin
          add_beat(fss_pkg::OpQuery, 1'b0, 8'($urandom), !open);
        end else begin
          foreach (qry_txt[k]) begin
            ch = qry_txt[k];
            if (ch >= "a" && ch <= "z" && $urandom_range(1)) begin
              ch = ch - 8'd32;
            end
            if ($urandom_range(15) == 0) begin
              add_beat(fss_pkg::OpQuery, 1'b0, 8'($urandom), 1'b0);
            end
            add_beat(fss_pkg::OpQuery, 1'b1, ch,
                     k == qry_txt.size() - 1 && !open && !tail);
          end
          if (tail && !open) begin
            add_beat(fss_pkg::OpQuery, 1'b0, 8'($urandom), 1'b1);
          end
        end
      end
    end
  endtask

  task automatic send_beat(beat_t b);
    while (!steady && $urandom_range(99) < IdleWeight) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_beat = b;
    in_valid_i     <= 1'b1;
    in_op_i        <= b.op;
    in_has_byte_i  <= b.has_byte;
    in_data_byte_i <= b.data;
    in_last_i      <= b.last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin : source
    int base;
    int hold_at;
    int quiet_from;
    int quiet_to;
    int i;
    clear_scorer();
    build_directed();
    base = stim_q.size();
    build_random();
    hold_at    = base + 100;
    quiet_from = base + 300;
    quiet_to   = base + 550;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < stim_q.size(); i++) begin
      steady = i >= quiet_from && i < quiet_to;
      if (i == hold_at) begin
        hold_now = 1'b1;
      end
      if (stim_q[i].drain) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (score_q.size() != 0);
      end
      send_beat(stim_q[i]);
    end
    in_valid_i <= 1'b0;
    while (score_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && score_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
design/fss_pkg.sv
design/fss_cand_ram.sv
design/fuzzy_subsequence_scorer_unit.sv
tb/tb_top.sv
